// ===== hdl/brvd_pkg.sv =====
// Package for the binary row value decoder: phase and result-kind enums,
// protocol type codes, result structs and type classification helpers.
// No dependencies.
`default_nettype none

package brvd_pkg;

    // Protocol column type codes
    localparam logic [7:0] CT_INT8      = 8'd1;
    localparam logic [7:0] CT_INT16     = 8'd2;
    localparam logic [7:0] CT_INT32     = 8'd3;
    localparam logic [7:0] CT_FP32      = 8'd4;
    localparam logic [7:0] CT_FP64      = 8'd5;
    localparam logic [7:0] CT_STAMP     = 8'd7;
    localparam logic [7:0] CT_INT64     = 8'd8;
    localparam logic [7:0] CT_INT32_ALT = 8'd9;
    localparam logic [7:0] CT_CAL_DATE  = 8'd10;
    localparam logic [7:0] CT_CLOCK     = 8'd11;
    localparam logic [7:0] CT_CAL_STAMP = 8'd12;
    localparam logic [7:0] CT_INT16_ALT = 8'd13;
    localparam logic [7:0] CT_BITFIELD  = 8'd16;
    localparam logic [7:0] CT_DEC_TEXT  = 8'd246;
    localparam logic [7:0] CT_LOB       = 8'd252;
    localparam logic [7:0] CT_VAR_TEXT  = 8'd253;
    localparam logic [7:0] CT_FIX_TEXT  = 8'd254;

    // Length-coded prefix bytes
    localparam logic [7:0] LCB_NULL = 8'hfb;
    localparam logic [7:0] LCB_LEN2 = 8'hfc;
    localparam logic [7:0] LCB_LEN3 = 8'hfd;
    localparam logic [7:0] LCB_LEN8 = 8'hfe;

    // Bytes of a temporal value that feed the result fields
    localparam int TFIELD_BYTES = 12;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_FIXED,
        PH_LCB_FIRST,
        PH_LCB_LEN,
        PH_STR,
        PH_TLEN,
        PH_TBODY
    } phase_t;

    typedef enum logic [3:0] {
        KIND_INT         = 4'd0,
        KIND_FLOAT32     = 4'd1,
        KIND_FLOAT64     = 4'd2,
        KIND_NULL        = 4'd3,
        KIND_STR_BYTE    = 4'd4,
        KIND_EMPTY_STR   = 4'd5,
        KIND_DATE        = 4'd6,
        KIND_DATETIME    = 4'd7,
        KIND_TIME        = 4'd8,
        KIND_UNSUPPORTED = 4'd9
    } kind_t;

    typedef logic [TFIELD_BYTES-1:0][7:0] tbytes_t;

    typedef struct packed {
        logic [15:0] year;
        logic [7:0]  month;
        logic [7:0]  day;
        logic [36:0] hours;
        logic [7:0]  minute;
        logic [7:0]  second;
        logic [31:0] microsecond;
        logic        negative;
    } tfields_t;

    typedef struct packed {
        kind_t       kind;
        logic [63:0] number;
        logic [7:0]  string_byte;
        tfields_t    tf;
        logic        last;
    } result_t;

    // Byte count of integer and float types, zero for everything else
    function automatic logic [3:0] fixed_width(input logic [7:0] t);
        logic [3:0] w;
        begin
            case (t) inside
                CT_INT8:                           w = 4'd1;
                CT_INT16, CT_INT16_ALT:            w = 4'd2;
                CT_INT32, CT_INT32_ALT, CT_FP32:   w = 4'd4;
                CT_INT64, CT_FP64:                 w = 4'd8;
                default:                           w = 4'd0;
            endcase
            return w;
        end
    endfunction

    function automatic logic is_string_type(input logic [7:0] t);
        return t inside {CT_DEC_TEXT, CT_LOB, CT_VAR_TEXT, CT_FIX_TEXT, CT_BITFIELD};
    endfunction

    function automatic logic is_temporal_type(input logic [7:0] t);
        return t inside {CT_STAMP, CT_CAL_DATE, CT_CLOCK, CT_CAL_STAMP};
    endfunction

endpackage

`default_nettype wire

// ===== hdl/brvd_temporal_fmt.sv =====
// Splits the captured bytes of a date, datetime or time value into fields.
// Depends on brvd_pkg.
`default_nettype none

module brvd_temporal_fmt
    import brvd_pkg::*;
(
    input  wire tbytes_t  tbytes,
    input  wire logic     is_time,
    input  wire logic     is_date,
    output tfields_t      fields
);

    logic [31:0] days;
    logic [36:0] day_hours;

    // time: sign, 4-byte day count, hour, minute, second, 4-byte fraction
    assign days      = {tbytes[4], tbytes[3], tbytes[2], tbytes[1]};
    // days * 24 as (days << 4) + (days << 3)
    assign day_hours = {1'b0, days, 4'b0} + {2'b0, days, 3'b0};

    always_comb
    begin
        fields = '0;
        if (is_time)
        begin
            fields.negative    = (tbytes[0] != 8'd0);
            fields.hours       = day_hours + 37'(tbytes[5]);
            fields.minute      = tbytes[6];
            fields.second      = tbytes[7];
            fields.microsecond = {tbytes[11], tbytes[10], tbytes[9], tbytes[8]};
        end
        else
        begin
            fields.year  = {tbytes[1], tbytes[0]};
            fields.month = tbytes[2];
            fields.day   = tbytes[3];
            if (!is_date)
            begin
                fields.hours       = 37'(tbytes[4]);
                fields.minute      = tbytes[5];
                fields.second      = tbytes[6];
                fields.microsecond = {tbytes[10], tbytes[9], tbytes[8], tbytes[7]};
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/binary_row_value_decoder_core.sv =====
// Top level of the binary row value decoder: byte-stream input, at most one typed
// result per transfer on the output. Depends on brvd_pkg and brvd_temporal_fmt.
`default_nettype none

// Takes one transfer per clock (tuser = 0: start of a value with its type,
// tuser = 1: one data byte) and yields at most one result per transfer,
// registered, in the cycle after it is taken. Every transfer is handled by the
// state registers and the logic that feeds the output register, so the rate is
// one transfer per cycle; the input stalls only while a result waits in the
// output register and the sink holds tready low.
// Integers come out sign- or zero-extended to 64 bits, strings one byte per
// result with tlast on the final byte, temporal values as one split result.
module binary_row_value_decoder_core
    import brvd_pkg::*;
#(
    parameter int TEMPORAL_BYTES = 12
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,

    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [7:0] column_type, [8] is_unsigned, [16:9] data_byte, [23:17] zero
    input  wire logic [23:0]  s_axis_tdata,
    // [0] op
    input  wire logic         s_axis_tuser,

    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [63:0] number, [71:64] string_byte, [87:72] year, [95:88] month,
    // [103:96] day, [140:104] hours, [148:141] minute, [156:149] second,
    // [188:157] microsecond, [189] negative, [191:190] zero
    output logic [191:0]      m_axis_tdata,
    // [3:0] result_kind
    output logic [3:0]        m_axis_tuser,
    output logic              m_axis_tlast
);

    localparam int TC_W = $clog2(TEMPORAL_BYTES + 1);

    phase_t      phase_reg, phase_next;
    logic [7:0]  type_reg, type_next;
    logic        uns_reg, uns_next;
    logic [3:0]  bytes_seen_reg, bytes_seen_next;
    logic [63:0] asm_reg, asm_next;
    logic [63:0] len_reg, len_next;
    logic [TC_W-1:0] tcount_reg, tcount_next;
    logic [7:0]  tstore_reg [TEMPORAL_BYTES];

    logic        out_valid_reg;
    result_t     out_reg;

    logic        accept;
    logic        op;
    logic [7:0]  col_type;
    logic        in_uns;
    logic [7:0]  dbyte;

    logic [63:0] asm_ins;
    logic [3:0]  bytes_inc;
    logic [3:0]  width_held;
    logic        fixed_done;
    logic        lcb_done;
    logic        lcb_prefix;
    logic        tbody_write;
    logic        tbody_done;
    logic        start_unsupported;
    logic [63:0] number_ext;

    tbytes_t     tb_next;
    tfields_t    tfields;

    logic        res_valid;
    result_t     res;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign op       = s_axis_tuser;
    assign col_type = s_axis_tdata[7:0];
    assign in_uns   = s_axis_tdata[8];
    assign dbyte    = s_axis_tdata[16:9];

    // assembly with the incoming byte dropped into its lane
    always_comb
    begin
        asm_ins = asm_reg;
        for (int k = 0; k < 8; k++)
        begin
            if (bytes_seen_reg[2:0] == 3'(k))
                asm_ins[8*k +: 8] = dbyte;
        end
    end

    assign bytes_inc  = bytes_seen_reg + 4'd1;
    assign width_held = fixed_width(type_reg);
    assign fixed_done = (bytes_inc >= width_held);
    assign lcb_done   = (bytes_inc >= len_reg[3:0]);
    assign lcb_prefix = (dbyte == LCB_LEN2) || (dbyte == LCB_LEN3) || (dbyte == LCB_LEN8);
    assign tbody_done = (len_reg == 64'd1);
    assign tbody_write = (phase_reg == PH_TBODY) && op;
    assign start_unsupported = !is_string_type(col_type) && (fixed_width(col_type) == 4'd0)
                               && !is_temporal_type(col_type);

    always_comb
    begin
        number_ext = asm_ins;
        if (!uns_reg && type_reg != CT_FP32 && type_reg != CT_FP64)
        begin
            case (width_held)
                4'd1:    number_ext = {{56{asm_ins[7]}}, asm_ins[7:0]};
                4'd2:    number_ext = {{48{asm_ins[15]}}, asm_ins[15:0]};
                4'd4:    number_ext = {{32{asm_ins[31]}}, asm_ins[31:0]};
                default: number_ext = asm_ins;
            endcase
        end
    end

    // Temporal bytes as they stand after this transfer; unwritten ones read zero
    generate
        for (genvar i = 0; i < TFIELD_BYTES; i++)
        begin : g_tb
            if (i < TEMPORAL_BYTES)
            begin : g_kept
                always_comb
                begin
                    if (tbody_write && tcount_reg == TC_W'(i))
                        tb_next[i] = dbyte;
                    else if (TC_W'(i) < tcount_reg)
                        tb_next[i] = tstore_reg[i];
                    else
                        tb_next[i] = 8'd0;
                end
            end
            else
            begin : g_none
                assign tb_next[i] = 8'd0;
            end
        end
    endgenerate

    brvd_temporal_fmt u_temporal_fmt (
        .tbytes  (tb_next),
        .is_time (type_reg == CT_CLOCK),
        .is_date (type_reg == CT_CAL_DATE),
        .fields  (tfields)
    );

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (op)
        begin
            case (phase_reg)
                PH_FIXED:
                    if (fixed_done)
                        phase_next = PH_IDLE;
                PH_LCB_FIRST:
                    if (dbyte == LCB_NULL)
                        phase_next = PH_IDLE;
                    else if (lcb_prefix)
                        phase_next = PH_LCB_LEN;
                    else if (dbyte == 8'd0)
                        phase_next = PH_IDLE;
                    else
                        phase_next = PH_STR;
                PH_LCB_LEN:
                    if (lcb_done)
                        phase_next = (asm_ins == 64'd0) ? PH_IDLE : PH_STR;
                PH_STR:
                    if (len_reg == 64'd1)
                        phase_next = PH_IDLE;
                PH_TLEN:
                    phase_next = (dbyte == 8'd0) ? PH_IDLE : PH_TBODY;
                PH_TBODY:
                    if (tbody_done)
                        phase_next = PH_IDLE;
                default:
                    phase_next = PH_IDLE;
            endcase
        end
        else if (is_string_type(col_type))
            phase_next = PH_LCB_FIRST;
        else if (fixed_width(col_type) != 4'd0)
            phase_next = PH_FIXED;
        else if (is_temporal_type(col_type))
            phase_next = PH_TLEN;
        else
            phase_next = PH_IDLE;
    end

    // Datapath state and result
    always_comb
    begin
        type_next       = type_reg;
        uns_next        = uns_reg;
        bytes_seen_next = bytes_seen_reg;
        asm_next        = asm_reg;
        len_next        = len_reg;
        tcount_next     = tcount_reg;
        res_valid       = 1'b0;
        res             = '0;
        res.kind        = KIND_INT;

        if (!op)
        begin
            type_next       = col_type;
            uns_next        = in_uns;
            bytes_seen_next = 4'd0;
            asm_next        = '0;
            len_next        = '0;
            tcount_next     = '0;
            if (start_unsupported)
            begin
                res_valid = 1'b1;
                res.kind  = KIND_UNSUPPORTED;
                res.last  = 1'b1;
            end
        end
        else
        begin
            case (phase_reg)
                PH_FIXED:
                begin
                    asm_next        = asm_ins;
                    bytes_seen_next = bytes_inc;
                    if (fixed_done)
                    begin
                        res_valid  = 1'b1;
                        res.last   = 1'b1;
                        res.number = number_ext;
                        if (type_reg == CT_FP32)
                            res.kind = KIND_FLOAT32;
                        else if (type_reg == CT_FP64)
                            res.kind = KIND_FLOAT64;
                        else
                            res.kind = KIND_INT;
                    end
                end
                PH_LCB_FIRST:
                begin
                    if (dbyte == LCB_NULL)
                    begin
                        res_valid = 1'b1;
                        res.kind  = KIND_NULL;
                        res.last  = 1'b1;
                    end
                    else if (lcb_prefix)
                    begin
                        asm_next        = '0;
                        bytes_seen_next = 4'd0;
                        if (dbyte == LCB_LEN2)
                            len_next = 64'd2;
                        else if (dbyte == LCB_LEN3)
                            len_next = 64'd3;
                        else
                            len_next = 64'd8;
                    end
                    else
                    begin
                        len_next = 64'(dbyte);
                        if (dbyte == 8'd0)
                        begin
                            res_valid = 1'b1;
                            res.kind  = KIND_EMPTY_STR;
                            res.last  = 1'b1;
                        end
                    end
                end
                PH_LCB_LEN:
                begin
                    asm_next        = asm_ins;
                    bytes_seen_next = bytes_inc;
                    if (lcb_done)
                    begin
                        len_next = asm_ins;
                        if (asm_ins == 64'd0)
                        begin
                            res_valid = 1'b1;
                            res.kind  = KIND_EMPTY_STR;
                            res.last  = 1'b1;
                        end
                    end
                end
                PH_STR:
                begin
                    len_next        = len_reg - 64'd1;
                    res_valid       = 1'b1;
                    res.kind        = KIND_STR_BYTE;
                    res.string_byte = dbyte;
                    res.last        = (len_reg == 64'd1);
                end
                PH_TLEN:
                begin
                    len_next    = 64'(dbyte);
                    tcount_next = '0;
                    if (dbyte == 8'd0)
                    begin
                        res_valid = 1'b1;
                        res.last  = 1'b1;
                        res.tf    = tfields;
                        if (type_reg == CT_CLOCK)
                            res.kind = KIND_TIME;
                        else if (type_reg == CT_CAL_DATE)
                            res.kind = KIND_DATE;
                        else
                            res.kind = KIND_DATETIME;
                    end
                end
                PH_TBODY:
                begin
                    len_next = len_reg - 64'd1;
                    // count saturates once the store is full; later bytes are dropped
                    if (tcount_reg != TC_W'(TEMPORAL_BYTES))
                        tcount_next = tcount_reg + TC_W'(1);
                    if (tbody_done)
                    begin
                        res_valid = 1'b1;
                        res.last  = 1'b1;
                        res.tf    = tfields;
                        if (type_reg == CT_CLOCK)
                            res.kind = KIND_TIME;
                        else if (type_reg == CT_CAL_DATE)
                            res.kind = KIND_DATE;
                        else
                            res.kind = KIND_DATETIME;
                    end
                end
                default:
                begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            type_reg       <= '0;
            uns_reg        <= 1'b0;
            bytes_seen_reg <= '0;
            asm_reg        <= '0;
            len_reg        <= '0;
            tcount_reg     <= '0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            type_reg       <= type_next;
            uns_reg        <= uns_next;
            bytes_seen_reg <= bytes_seen_next;
            asm_reg        <= asm_next;
            len_reg        <= len_next;
            tcount_reg     <= tcount_next;
        end
    end

    generate
        for (genvar i = 0; i < TEMPORAL_BYTES; i++)
        begin : g_store
            always_ff @(posedge clk)
            begin
                if (accept && tbody_write && tcount_reg == TC_W'(i))
                    tstore_reg[i] <= dbyte;
            end
        end
    endgenerate

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s_axis_tready)
            out_valid_reg <= accept && res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
            out_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tlast  = out_reg.last;
    assign m_axis_tdata  = {2'b00,
                            out_reg.tf.negative,
                            out_reg.tf.microsecond,
                            out_reg.tf.second,
                            out_reg.tf.minute,
                            out_reg.tf.hours,
                            out_reg.tf.day,
                            out_reg.tf.month,
                            out_reg.tf.year,
                            out_reg.string_byte,
                            out_reg.number};

endmodule

`default_nettype wire
